>>> src/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sha_pkg;

   // Default depth of the block queue between packer and round engine.
   localparam int QueueDepth = 2;

   // Front state codes.
   localparam logic [1:0] FR_IDLE  = 2'd0;
   localparam logic [1:0] FR_PAD80 = 2'd1;
   localparam logic [1:0] FR_PADZ  = 2'd2;
   localparam logic [1:0] FR_LEN   = 2'd3;

   // Back state codes.
   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_RUN  = 2'd1;
   localparam logic [1:0] BK_ADD  = 2'd2;

   localparam logic [7:0]  PAD_BYTE  = 8'h80;
   localparam logic [5:0]  LEN_START = 6'd55;
   localparam logic [5:0]  BLK_LAST  = 6'h3F;

   // Initial hash words, word 0 is A.
   localparam logic [7:0][31:0] INIT_WORDS = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

   // Input word: one message byte with its flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   // Result word: one digest word.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // One 64-byte block, word 0 first in message order.
   typedef struct packed {
      logic             final_blk;
      logic [15:0][31:0] words;
   } blk_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // Round constants.
   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_k = k;
   endfunction

endpackage

`default_nettype wire

>>> src/sha_front.sv
// Byte packer: assembles message bytes into blocks and appends the padding.
// Depends on sha_pkg; feeds the block queue.
`default_nettype none

module sha_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sha_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  q_push,
   output sha_pkg::blk_type      q_data
);
   import sha_pkg::*;

   logic [1:0]        state_ff, state_in;
   logic [5:0]        fill_ff, fill_in;
   logic [60:0]       count_ff, count_in;
   logic [15:0][31:0] buf_ff;
   logic              can_write, take, wr_en;
   logic [7:0]        wr_byte;
   logic [63:0]       len_bits;

   // A byte that completes a block needs room in the queue.
   assign can_write = !(fill_ff == BLK_LAST && q_full);
   assign req_full  = (state_ff != FR_IDLE) || !can_write;
   assign take      = req_push && !req_full;
   assign len_bits  = {count_ff, 3'b000};

   // Pick the byte written this cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_byte = 8'h00;
      case (state_ff)
         FR_IDLE: begin
            wr_en   = take && req_data.byte_valid;
            wr_byte = req_data.data_byte;
         end
         FR_PAD80: begin
            wr_en   = can_write;
            wr_byte = PAD_BYTE;
         end
         FR_PADZ: begin
            wr_en   = can_write;
            wr_byte = 8'h00;
         end
         FR_LEN: begin
            wr_en   = can_write;
            wr_byte = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
         end
         default: begin
            wr_en   = 1'b0;
            wr_byte = 8'h00;
         end
      endcase
   end

   // Next state, fill level and byte count.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      case (state_ff)
         FR_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + 61'd1;
            end
            if (take && req_data.end_of_message) begin
               state_in = FR_PAD80;
            end
         end
         FR_PAD80, FR_PADZ: begin
            if (wr_en) begin
               state_in = (fill_ff == LEN_START) ? FR_LEN : FR_PADZ;
            end
         end
         FR_LEN: begin
            if (wr_en && fill_ff == BLK_LAST) begin
               state_in = FR_IDLE;
               count_in = '0;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // Hand the block over as its last byte arrives.
   always_comb begin
      q_push               = wr_en && (fill_ff == BLK_LAST);
      q_data.final_blk     = (state_ff == FR_LEN);
      q_data.words         = buf_ff;
      q_data.words[15][7:0] = wr_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // Block buffer, big-endian byte lanes.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

endmodule

`default_nettype wire

>>> src/sha_fifo.sv
// Short block queue between the packer and the round engine.
// Depends on sha_pkg for the block type.
`default_nettype none

module sha_fifo #(
   parameter int Depth = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sha_pkg::blk_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output sha_pkg::blk_type      pop_data
);
   import sha_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   blk_type            mem_ff [Depth];
   logic [PtrW-1:0]    wr_ff, rd_ff;
   logic [CntW-1:0]    cnt_ff;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == CntW'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // Pointers wrap at the depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> src/sha_back.sv
// Round engine: 64 compression rounds per block and the digest output stage.
// Depends on sha_pkg; takes blocks from the block queue.
`default_nettype none

module sha_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire sha_pkg::blk_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;

   logic [1:0]        state_ff;
   logic [5:0]        rnd_ff;
   logic              fin_ff;
   logic [7:0][31:0]  h_ff, v_ff, sum;
   logic [15:0][31:0] w_ff;
   logic [7:0][31:0]  dig_ff;
   logic              busy_ff;
   logic [2:0]        oidx_ff;
   logic [31:0]       t1, t2, w_new;

   // Start a block only once any earlier digest has gone out.
   assign q_pop = (state_ff == BK_IDLE) && !q_empty && !busy_ff;

   // One round and one schedule step.
   always_comb begin
      t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + round_k(rnd_ff) + w_ff[0];
      t2 = big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
      for (int i = 0; i < 8; i++) begin
         sum[i] = h_ff[i] + v_ff[i];
      end
   end

   // Control, chaining value and output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rnd_ff   <= '0;
         fin_ff   <= 1'b0;
         h_ff     <= INIT_WORDS;
         busy_ff  <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         case (state_ff)
            BK_IDLE: begin
               if (q_pop) begin
                  state_ff <= BK_RUN;
                  rnd_ff   <= '0;
                  fin_ff   <= q_data.final_blk;
               end
            end
            BK_RUN: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  state_ff <= BK_ADD;
               end
            end
            BK_ADD: begin
               state_ff <= BK_IDLE;
               if (fin_ff) begin
                  h_ff    <= INIT_WORDS;
                  busy_ff <= 1'b1;
                  oidx_ff <= '0;
               end else begin
                  h_ff <= sum;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
         if (busy_ff && rsp_pop) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Working variables, schedule window and digest copy.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         v_ff <= h_ff;
         w_ff <= q_data.words;
      end else if (state_ff == BK_RUN) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
      if (state_ff == BK_ADD && fin_ff) begin
         dig_ff <= sum;
      end
   end

   assign rsp_empty            = !busy_ff;
   assign rsp_data.digest_word = dig_ff[oidx_ff];
   assign rsp_data.word_index  = oidx_ff;
   assign rsp_data.last_word   = (oidx_ff == 3'd7);

endmodule

`default_nettype wire

>>> src/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: packer, block queue, round engine.
// Depends on sha_pkg, sha_front, sha_fifo and sha_back.
//
//   Port group   Direction   Handshake            Word
//   req_*        in          req_push / req_full  one message byte and flags
//   rsp_*        out         rsp_pop / rsp_empty  one 32-bit digest word
//
// The packer takes one byte per cycle while req_full is low; after the end mark it
// writes the 9 to 72 padding and length bytes with req_full high.
// The round engine runs one round per cycle, 64 rounds per 64-byte block.
// Sustained input is about one byte per cycle, set by the round loop, while digest words are taken promptly.
// Eight digest words follow the last block; the next block waits for them.
// Synchronous reset restores the initial hash words and empties the queue.
`default_nettype none

module sha256_message_hasher #(
   parameter int QDepth = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sha_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   blk_type q_in, q_out;

   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   sha_fifo #(.Depth(QDepth)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   sha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> src/sha_checker.sv
// Port-level checks of the SHA-256 message hasher, bound to the top level.
// Depends on sha_pkg for the result word type.
`default_nettype none

module sha_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire sha_pkg::rsp_type rsp_data
);

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered after reset");

   // A waiting word holds until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting word changed");

   // Words of one digest follow in order.
   a_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_word) |=>
      (!rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest word skipped");

   // The last flag marks word seven only.
   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last flag misplaced");

   // A new digest never starts in the cycle after the last word.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last_word) |=> rsp_empty)
      else $error("digest started without gap");

endmodule

bind sha256_message_hasher sha_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> test/sha256_digest_checker.sv
// Checker for the SHA-256 message hasher: watches both queue ports, predicts digests.
// Depends on sha_pkg for the word types and the initial hash words.
`timescale 1ns / 1ps
`default_nettype none

module sha256_digest_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic             req_full,
   input  wire sha_pkg::req_type req_data,
   input  wire logic             rsp_empty,
   input  wire logic             rsp_pop,
   input  wire sha_pkg::rsp_type rsp_data,
   output int                    error_count,
   output int                    digests_pending
);
   import sha_pkg::*;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Predictor state: chaining value, current block and message length.
   logic [7:0][31:0] hash_state;
   logic [63:0][7:0] block_bytes;
   logic [5:0]       fill_level;
   logic [60:0]      byte_total;
   rsp_type          digest_words[$];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds on the held block and fold into the chaining value.
   task automatic compress_held_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   task automatic append_byte(input logic [7:0] b);
      block_bytes[fill_level] = b;
      fill_level = fill_level + 6'd1;
      if (fill_level == 6'd0) compress_held_block();
   endtask

   task automatic start_new_message();
      hash_state = INIT_WORDS;
      fill_level = '0;
      byte_total = '0;
   endtask

   // Append the byte; at the end mark, pad, close the message and queue its eight digest words.
   task automatic predict_word(input req_type w);
      logic [63:0] bit_len;
      rsp_type r;
      if (w.byte_valid) begin
         append_byte(w.data_byte);
         byte_total = byte_total + 61'd1;
      end
      if (w.end_of_message) begin
         bit_len = {byte_total, 3'b000};
         append_byte(PAD_BYTE);
         while (fill_level != 6'd56) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_words.push_back(r);
         end
         start_new_message();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      start_new_message();
   end

   assign digests_pending = digest_words.size();

   // Sample both ports at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         start_new_message();
         digest_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (digest_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.digest_word, 32'h0);
            end else begin
               want = digest_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index !== want.word_index)
                  report_mismatch("word_index", 32'(rsp_data.word_index), 32'(want.word_index));
               if (rsp_data.last_word !== want.last_word)
                  report_mismatch("last_word", 32'(rsp_data.last_word), 32'(want.last_word));
            end
         end
         if (req_push && !req_full) predict_word(req_data);
      end
   end
endmodule

`default_nettype wire

>>> test/sha256_message_hasher_tb.sv
// Testbench top for the SHA-256 message hasher: drives messages, pops digests.
// Depends on sha_pkg, sha256_message_hasher and sha256_digest_checker.
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher_tb;
   import sha_pkg::*;

   localparam int CycleLimit = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   int      error_count, digests_pending;
   int      cycle_count = 0;
   bit      hold_off = 1'b0;
   bit      calm_phase = 1'b0;
   int      pushed = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sha256_message_hasher dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data));

   sha256_digest_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .error_count(error_count), .digests_pending(digests_pending));

   // Offer one word and hold it until accepted; random gaps before it.
   task automatic send_word(input logic [7:0] b, input bit bv, input bit eom);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      pushed++;
   endtask

   // Stop offering words before the sender waits.
   task automatic stop_sending();
      req_push <= 1'b0;
   endtask

   task automatic send_message(input int len, input bit empty_close);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
      end
      if (empty_close || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   // Result side: random pop stalls, plus a long hold-off on request.
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL sha256_message_hasher");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: empty message, all-zero and all-ones bytes, short messages.
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hA5, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b1);
      send_message(3, 1'b0);
      // Long receiver stall while padding-boundary messages keep coming, then a full drain.
      hold_off = 1'b1;
      send_message(55, 1'b0);
      send_message(56, 1'b1);
      send_message(64, 1'b0);
      stop_sending();
      wait (!hold_off && digests_pending == 0);
      // Random messages, mostly short, some across block boundaries.
      while (pushed < 430) begin
         if ($urandom_range(0, 7) == 0) send_message($urandom_range(56, 130), $urandom_range(0, 1));
         else send_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
      end
      calm_phase = 1'b1;
      while (pushed < 470) send_message($urandom_range(0, 10), 1'b0);
      stop_sending();
      wait (digests_pending == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && digests_pending == 0)
         $display("PASS sha256_message_hasher");
      else
         $display("FAIL sha256_message_hasher");
      $finish;
   end
endmodule

`default_nettype wire
